// File: rtl/idf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idf_pkg
// Shared types and constants of the delta unfilter and flip unit.
// ----------------------------------------------------------------------------
package idf_pkg;

    // field widths
    localparam int PIX_W        = 8;
    localparam int ROW_W        = 24;
    localparam int COL_OUT_W    = 14;
    localparam int WIDTH_REG_W  = 13;
    localparam int HEIGHT_REG_W = 25;
    localparam int TDATA_OUT_W  = 48;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    // image geometry
    localparam int BYTES_PER_PIXEL = 4;
    localparam logic [HEIGHT_REG_W-1:0] MAX_HEIGHT = 25'd16777216;

    // register index, taken from paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // status from the register block to the datapath
    typedef struct packed {
        logic             restart;
        logic [ROW_W-1:0] last_row;
    } cfg_status_t;

endpackage

// File: rtl/image_delta_unfilter_flip_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_delta_unfilter_flip_unit
// Reconstructs delta-filtered bytes of a four-byte-per-pixel image and tags
// each with its byte column and vertically flipped destination row.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries one filtered byte per transfer in raster order. Each
//   accepted byte yields exactly one transfer on m_tdata/m_tlast: the
//   reconstructed byte, its flipped row (height-1-row) and its byte column;
//   m_tlast marks the final byte of the image, after which the column and
//   row counters start over for the next image.
//   The APB port sets width_pixels (address 0) and height_rows (address 4);
//   any write restarts the image. Write only while no transfer is in flight.
// Timing:
//   one byte per cycle sustained while m_tready is high. A result is held first
//   in stage 1, during the registered read of the line store that holds the
//   previous row, then in the output register; the add and the write back of
//   the new byte happen as it moves from stage 1 into the output register.
//   When m_tready is low the output register holds and the stage behind it
//   takes one more byte only if it is empty; s_tready stays low until the output drains.
// Reset:
//   rst_n clears counters, recent-byte history and valid flags; the size
//   becomes 1 x 1 pixel. The line store is not cleared, since the first row
//   of every image writes each column before a later row reads it.
// ----------------------------------------------------------------------------
module image_delta_unfilter_flip_unit
    import idf_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [PIX_W-1:0]       s_tdata,    // [7:0] delta_byte
    // output stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,    // [7:0] pixel_byte, [31:8] dest_row,
                                               // [45:32] byte_column, [47:46] zero
    output logic                   m_tlast,    // last_of_image
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int DEPTH  = MAX_WIDTH * BYTES_PER_PIXEL;
    localparam int ADDR_W = $clog2(DEPTH);

    cfg_status_t       status;
    logic [ADDR_W-1:0] last_col;

    // counters for the next input byte
    logic [ADDR_W-1:0] col_reg;
    logic [ADDR_W-1:0] col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;

    // stage 1: line store read in flight
    logic              s1_valid_reg;
    logic [PIX_W-1:0]  s1_delta_reg;
    logic [ADDR_W-1:0] s1_col_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic              s1_first_row_reg;
    logic              s1_use_left_reg;
    logic              s1_last_reg;

    // output register
    logic                 out_valid_reg;
    logic [PIX_W-1:0]     out_pix_reg;
    logic [ROW_W-1:0]     out_dest_reg;
    logic [COL_OUT_W-1:0] out_col_reg;
    logic                 out_last_reg;

    logic [4*PIX_W-1:0] recent_reg;

    logic              in_xfer;
    logic              s1_adv;
    logic              at_last;
    logic              at_row_end;
    logic [PIX_W-1:0]  above_byte;
    logic [PIX_W-1:0]  pix;

    assign pready = 1'b1;

    idf_cfg_regs #(
        .MAX_WIDTH (MAX_WIDTH),
        .ADDR_W    (ADDR_W)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .status   (status),
        .last_col (last_col)
    );

    idf_line_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (in_xfer),
        .rd_addr (col_reg),
        .rd_data (above_byte),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (pix)
    );

    // handshake
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign in_xfer  = s_tvalid && s_tready;

    // position of the incoming byte
    assign at_row_end = (col_reg == last_col);
    assign at_last    = at_row_end && (row_reg == status.last_row);

    always_comb
    begin
        priority if (at_last)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (at_row_end)
        begin
            col_next = '0;
            row_next = row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + ADDR_W'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (status.restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_xfer)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage 1 register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_delta_reg     <= s_tdata;
            s1_col_reg       <= col_reg;
            s1_row_reg       <= row_reg;
            s1_first_row_reg <= (row_reg == '0);
            s1_use_left_reg  <= ({1'b0, col_reg} >= (ADDR_W+1)'(BYTES_PER_PIXEL));
            s1_last_reg      <= at_last;
        end
    end

    // reconstruct: left neighbor in the first row (delta as is in its first pixel), byte above otherwise
    always_comb
    begin
        priority if (!s1_first_row_reg)
        begin
            pix = s1_delta_reg + above_byte;
        end
        else if (s1_use_left_reg)
        begin
            pix = s1_delta_reg + recent_reg[4*PIX_W-1 -: PIX_W];
        end
        else
        begin
            pix = s1_delta_reg;
        end
    end

    // history of the last four reconstructed bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg <= '0;
        end
        else if (status.restart)
        begin
            recent_reg <= '0;
        end
        else if (s1_adv)
        begin
            recent_reg <= {recent_reg[3*PIX_W-1:0], pix};
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_pix_reg  <= pix;
            out_dest_reg <= status.last_row - s1_row_reg;
            out_col_reg  <= COL_OUT_W'(s1_col_reg);
            out_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_col_reg, out_dest_reg, out_pix_reg};
    assign m_tlast  = out_last_reg;

endmodule

// File: rtl/idf_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idf_cfg_regs
// APB register block; holds the image size and its clamped last column/row.
// ----------------------------------------------------------------------------
module idf_cfg_regs
    import idf_pkg::*;
#(
    parameter int MAX_WIDTH = 4096,
    parameter int ADDR_W    = 14
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output cfg_status_t           status,
    output logic [ADDR_W-1:0]     last_col
);

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [ADDR_W-1:0]       last_col_reg;
    logic [ROW_W-1:0]        last_row_reg;

    logic                    wr_en;
    logic                    reg_idx;
    logic [WIDTH_REG_W-1:0]  wdata_width;
    logic [HEIGHT_REG_W-1:0] wdata_height;
    int unsigned             eff_width;
    logic [ADDR_W-1:0]       last_col_next;
    logic [ROW_W-1:0]        last_row_next;

    assign wr_en        = psel && penable && pwrite;
    assign reg_idx      = paddr[2];
    assign wdata_width  = pwdata[WIDTH_REG_W-1:0];
    assign wdata_height = pwdata[HEIGHT_REG_W-1:0];

    // clamp width to 1..MAX_WIDTH, last byte column of a row
    always_comb
    begin
        eff_width = 32'(wdata_width);
        if (wdata_width == '0)
        begin
            eff_width = 1;
        end
        else if (32'(wdata_width) > 32'(MAX_WIDTH))
        begin
            eff_width = 32'(MAX_WIDTH);
        end
        last_col_next = ADDR_W'(eff_width * BYTES_PER_PIXEL - 1);
    end

    // clamp height to 1..MAX_HEIGHT, last source row
    always_comb
    begin
        priority if (wdata_height == '0)
        begin
            last_row_next = '0;
        end
        else if (wdata_height >= MAX_HEIGHT)
        begin
            last_row_next = '1;
        end
        else
        begin
            last_row_next = wdata_height[ROW_W-1:0] - ROW_W'(1);
        end
    end

    // register writes; any write restarts the image
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_REG_W'(1);
            height_reg   <= HEIGHT_REG_W'(1);
            last_col_reg <= ADDR_W'(BYTES_PER_PIXEL - 1);
            last_row_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                unique case (reg_idx)
                    REG_WIDTH:
                    begin
                        width_reg    <= wdata_width;
                        last_col_reg <= last_col_next;
                    end
                    REG_HEIGHT:
                    begin
                        height_reg   <= wdata_height;
                        last_row_reg <= last_row_next;
                    end
                endcase
            end
        end
    end

    // read back
    always_comb
    begin
        unique case (reg_idx)
            REG_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_HEIGHT: prdata = APB_DATA_W'(height_reg);
        endcase
    end

    // restart takes effect at the same edge as the register write
    assign status.restart  = wr_en;
    assign status.last_row = last_row_reg;
    assign last_col        = last_col_reg;

endmodule

// File: rtl/idf_line_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idf_line_mem
// Single-port-write, single-port-read line store with registered read data.
// ----------------------------------------------------------------------------
module idf_line_mem
    import idf_pkg::*;
#(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [PIX_W-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [PIX_W-1:0]  wr_data
);

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/idf_port_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idf_port_checker
// Port-level assertions for the unfilter unit, bound to the top level.
// ----------------------------------------------------------------------------
module idf_port_checker
    import idf_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [TDATA_OUT_W-1:0] m_tdata,
    input logic                   m_tlast
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output transfer changed");

    // empty output register never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // last byte of an image lands in flipped row zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[31:8] == 24'd0)
        else $error("last byte not in destination row zero");

    // a row is whole pixels, so the last column is 3 mod 4
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[33:32] == 2'b11)
        else $error("last byte not on a pixel boundary");

endmodule

bind image_delta_unfilter_flip_unit idf_port_checker u_idf_port_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
